// ===== sv/fca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and helpers for the FAT16 chain analyser.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  // Request opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ANALYZE = 2'd1;
  localparam logic [1:0] OP_NEXT    = 2'd2;

  // Entry values
  localparam logic [15:0] V_FREE     = 16'h0000;
  localparam logic [15:0] V_BAD      = 16'hFFF7;
  localparam logic [15:0] V_EOC_MIN  = 16'hFFF8;
  localparam logic [15:0] V_LINK_MIN = 16'h0002;
  localparam logic [15:0] V_LINK_MAX = 16'hFFEF;
  localparam logic [15:0] V_CLEAN    = 16'hFFFF;
  localparam logic [15:0] V_DIRTY    = 16'hFF7F;

  localparam logic [15:0] LIMIT_RST  = 16'd1000;

  // Volume state codes
  localparam logic [1:0] VOL_CLEAN = 2'd0;
  localparam logic [1:0] VOL_DIRTY = 2'd1;
  localparam logic [1:0] VOL_OTHER = 2'd2;

  // Chain end codes
  localparam logic [1:0] END_EOC   = 2'd0;
  localparam logic [1:0] END_BAD   = 2'd1;
  localparam logic [1:0] END_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
  } fca_req_t;

  typedef struct packed {
    logic [7:0]  free_count;
    logic [7:0]  used_count;
    logic [7:0]  bad_count;
    logic [7:0]  end_marker_count;
    logic [7:0]  media_byte;
    logic [1:0]  volume_state;
    logic        chain_found;
    logic [7:0]  chain_start;
    logic [15:0] chain_length;
    logic [1:0]  chain_end_kind;
    logic [7:0]  chain_number;
  } fca_res_t;

  // Table memory port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

  // Pointed-to map port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic [IDX_W-1:0] raddr;
  } map_req_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] c);
    sat_inc8 = (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  function automatic logic is_link(input logic [15:0] v);
    is_link = (v >= V_LINK_MIN) && (v <= V_LINK_MAX) &&
              ({1'b0, v} < 17'(TABLE_ENTRIES));
  endfunction

endpackage

// ===== sv/fca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_ctrl
// Sequencer: map clear after reset, analyse passes, scan and chain walk.
// ----------------------------------------------------------------------------
module fca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  fca_pkg::fca_req_t req_i,
  input  logic [15:0]       limit_i,
  output logic              done_o,
  output fca_pkg::fca_res_t res_o,
  output fca_pkg::tbl_req_t tbl_o,
  input  logic [15:0]       tbl_rdata_i,
  output fca_pkg::map_req_t map_o,
  input  logic              map_rdata_i
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_ACNT = 7'b0000100,
    S_AMAP = 7'b0001000,
    S_AFIN = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_WALK = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    PH_CNT  = 2'd0,
    PH_MAP  = 2'd1,
    PH_SCAN = 2'd2
  } phase_e;

  localparam logic [fca_pkg::IDX_W-1:0] IDX_LAST = '1;
  localparam logic [fca_pkg::CNT_W-1:0] CUR_END  = fca_pkg::CNT_W'(fca_pkg::TABLE_ENTRIES);
  localparam logic [fca_pkg::CNT_W-1:0] CUR_BASE = fca_pkg::CNT_W'(2);

  state_e                       state_q, state_d;
  logic [fca_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         rd_vld_q, rd_vld_d;
  phase_e                       rd_ph_q, rd_ph_d;
  logic [fca_pkg::IDX_W-1:0]    rd_idx_q;
  logic [7:0]                   fr_q, fr_d, us_q, us_d, bd_q, bd_d, eo_q, eo_d;
  logic [7:0]                   media_q, media_d;
  logic [1:0]                   vol_q, vol_d;
  logic [fca_pkg::CNT_W-1:0]    cursor_q, cursor_d;
  logic [7:0]                   chains_q, chains_d;
  logic [fca_pkg::IDX_W-1:0]    start_q, start_d;
  logic [15:0]                  len_q, len_d;
  logic                         done_q, done_d;
  fca_pkg::fca_res_t            res_q, res_d;
  logic                         accept;
  logic                         hit;
  logic [1:0]                   end_kind;
  logic                         walk_done;

  assign accept = start_i && (state_q == S_IDLE);
  assign hit    = rd_vld_q && (rd_ph_q == PH_SCAN) && (tbl_rdata_i != fca_pkg::V_FREE) &&
                  (tbl_rdata_i != fca_pkg::V_BAD) && !map_rdata_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rd_vld_d = 1'b0;
    rd_ph_d  = rd_ph_q;
    fr_d     = fr_q;
    us_d     = us_q;
    bd_d     = bd_q;
    eo_d     = eo_q;
    media_d  = media_q;
    vol_d    = vol_q;
    cursor_d = cursor_q;
    chains_d = chains_q;
    start_d  = start_q;
    len_d    = len_q;
    done_d   = 1'b0;
    res_d    = res_q;
    end_kind = fca_pkg::END_LIMIT;
    walk_done = 1'b0;

    tbl_o.we    = 1'b0;
    tbl_o.waddr = req_i.entry_index;
    tbl_o.wdata = req_i.entry_value;
    tbl_o.raddr = cnt_q[fca_pkg::IDX_W-1:0];
    map_o.we    = 1'b0;
    map_o.waddr = cnt_q[fca_pkg::IDX_W-1:0];
    map_o.wdata = 1'b0;
    map_o.raddr = cnt_q[fca_pkg::IDX_W-1:0];

    unique case (state_q)
      S_CLR: begin
        map_o.we = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q[fca_pkg::IDX_W-1:0] == IDX_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.opcode)
            fca_pkg::OP_WRITE: begin
              tbl_o.we = 1'b1;
              done_d   = 1'b1;
              res_d    = '0;
            end
            fca_pkg::OP_ANALYZE: begin
              cnt_d   = '0;
              fr_d    = '0;
              us_d    = '0;
              bd_d    = '0;
              eo_d    = '0;
              state_d = S_ACNT;
            end
            fca_pkg::OP_NEXT: begin
              cnt_d   = cursor_q;
              state_d = S_SCAN;
            end
            default: begin
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end
      S_ACNT: begin
        // read every entry, clear its map bit on the way
        rd_vld_d = 1'b1;
        rd_ph_d  = PH_CNT;
        map_o.we = 1'b1;
        if (cnt_q[fca_pkg::IDX_W-1:0] == IDX_LAST) begin
          cnt_d   = CUR_BASE;
          state_d = S_AMAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_AMAP: begin
        rd_vld_d = 1'b1;
        rd_ph_d  = PH_MAP;
        if (cnt_q[fca_pkg::IDX_W-1:0] == IDX_LAST) begin
          state_d = S_AFIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_AFIN: begin
        res_d                  = '0;
        res_d.free_count       = fr_q;
        res_d.used_count       = us_q;
        res_d.bad_count        = bd_q;
        res_d.end_marker_count = eo_q;
        res_d.media_byte       = media_q;
        res_d.volume_state     = vol_q;
        done_d                 = 1'b1;
        cursor_d               = (us_q == 8'd0) ? CUR_END : CUR_BASE;
        chains_d               = '0;
        state_d                = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          // re-read the start entry for the walk
          tbl_o.raddr = rd_idx_q;
          start_d     = rd_idx_q;
          cursor_d    = {1'b0, rd_idx_q} + 1'b1;
          len_d       = 16'd1;
          state_d     = S_WALK;
        end else if (cnt_q[fca_pkg::CNT_W-1]) begin
          if (!rd_vld_q) begin
            done_d   = 1'b1;
            res_d    = '0;
            cursor_d = CUR_END;
            state_d  = S_IDLE;
          end
        end else begin
          rd_vld_d = 1'b1;
          rd_ph_d  = PH_SCAN;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      S_WALK: begin
        if (len_q >= limit_i) begin
          walk_done = 1'b1;
          end_kind  = fca_pkg::END_LIMIT;
        end else if (tbl_rdata_i >= fca_pkg::V_EOC_MIN) begin
          walk_done = 1'b1;
          end_kind  = fca_pkg::END_EOC;
        end else if (fca_pkg::is_link(tbl_rdata_i)) begin
          tbl_o.raddr = tbl_rdata_i[fca_pkg::IDX_W-1:0];
          len_d       = len_q + 16'd1;
        end else begin
          walk_done = 1'b1;
          end_kind  = fca_pkg::END_BAD;
        end
        if (walk_done) begin
          chains_d             = fca_pkg::sat_inc8(chains_q);
          res_d                = '0;
          res_d.chain_found    = 1'b1;
          res_d.chain_start    = 8'(start_q);
          res_d.chain_length   = len_q;
          res_d.chain_end_kind = end_kind;
          res_d.chain_number   = fca_pkg::sat_inc8(chains_q);
          done_d               = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // read-data stage of the analyse passes
    if (rd_vld_q && (rd_ph_q == PH_CNT)) begin
      if (rd_idx_q == fca_pkg::IDX_W'(0)) begin
        media_d = tbl_rdata_i[7:0];
      end else if (rd_idx_q == fca_pkg::IDX_W'(1)) begin
        if (tbl_rdata_i == fca_pkg::V_CLEAN) begin
          vol_d = fca_pkg::VOL_CLEAN;
        end else if (tbl_rdata_i == fca_pkg::V_DIRTY) begin
          vol_d = fca_pkg::VOL_DIRTY;
        end else begin
          vol_d = fca_pkg::VOL_OTHER;
        end
      end else if (tbl_rdata_i == fca_pkg::V_FREE) begin
        fr_d = fca_pkg::sat_inc8(fr_q);
      end else if (tbl_rdata_i == fca_pkg::V_BAD) begin
        bd_d = fca_pkg::sat_inc8(bd_q);
      end else if (tbl_rdata_i >= fca_pkg::V_EOC_MIN) begin
        eo_d = fca_pkg::sat_inc8(eo_q);
        us_d = fca_pkg::sat_inc8(us_q);
      end else if ((tbl_rdata_i >= fca_pkg::V_LINK_MIN) &&
                   (tbl_rdata_i <= fca_pkg::V_LINK_MAX)) begin
        us_d = fca_pkg::sat_inc8(us_q);
      end
    end
    if (rd_vld_q && (rd_ph_q == PH_MAP) && fca_pkg::is_link(tbl_rdata_i)) begin
      map_o.we    = 1'b1;
      map_o.waddr = tbl_rdata_i[fca_pkg::IDX_W-1:0];
      map_o.wdata = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_ph_q  <= PH_CNT;
      cursor_q <= CUR_BASE;
      chains_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      rd_ph_q  <= rd_ph_d;
      cursor_q <= cursor_d;
      chains_q <= chains_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[fca_pkg::IDX_W-1:0];
    fr_q     <= fr_d;
    us_q     <= us_d;
    bd_q     <= bd_d;
    eo_q     <= eo_d;
    media_q  <= media_d;
    vol_q    <= vol_d;
    start_q  <= start_d;
    len_q    <= len_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  a_analyze_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.opcode == fca_pkg::OP_ANALYZE)) |=> busy_o)
    else $error("analyse request did not start a pass");

  a_scan_no_map_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) || (state_q == S_WALK)) |-> !map_o.we)
    else $error("map written during scan or walk");

  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((len_q <= limit_i) || (len_q == 16'd1)))
    else $error("chain walk ran past the length limit");

endmodule

// ===== sv/fat16_chain_analyzer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16_chain_analyzer
// FAT16 allocation-table store with table analysis and chain walking.
// ----------------------------------------------------------------------------
// Write and unused opcodes give their result in the cycle after the request is accepted.
// Analyse: one table-RAM read a cycle, count pass then map pass.
// Next-chain: scan from the cursor, then walk the chain, one table read per link;
//   none left: an all-zero result, also with the cursor already at the end.
// Reset: a pass clears the pointed-to map, busy high throughout.
// One request at a time; each result shows for one cycle on done_o, no stall.
// ----------------------------------------------------------------------------
module fat16_chain_analyzer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fca_pkg::fca_req_t req_i,
  output logic              done_o,
  output fca_pkg::fca_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  // chain length limit register
  logic [15:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= fca_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  fca_pkg::tbl_req_t tbl_req;
  fca_pkg::map_req_t map_req;
  logic [15:0]       tbl_rdata;
  logic              map_rdata;

  // sequencer: owns both RAM ports and the result register
  fca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .limit_i     (limit_q),
    .done_o      (done_o),
    .res_o       (res_o),
    .tbl_o       (tbl_req),
    .tbl_rdata_i (tbl_rdata),
    .map_o       (map_req),
    .map_rdata_i (map_rdata)
  );

  // allocation table, never reset; written only from idle
  fca_ram #(
    .WIDTH (16),
    .DEPTH (fca_pkg::TABLE_ENTRIES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we),
    .waddr_i (tbl_req.waddr),
    .wdata_i (tbl_req.wdata),
    .raddr_i (tbl_req.raddr),
    .rdata_o (tbl_rdata)
  );

  // pointed-to map, cleared after reset and at the start of each analyse
  fca_ram #(
    .WIDTH (1),
    .DEPTH (fca_pkg::TABLE_ENTRIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_req.we),
    .waddr_i (map_req.waddr),
    .wdata_i (map_req.wdata),
    .raddr_i (map_req.raddr),
    .rdata_o (map_rdata)
  );

endmodule

// ===== sim/fat16_chain_analyzer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16_chain_analyzer_test
// Self-checking bench for the FAT16 chain analyser. A directed table covers
// the empty table, reserved and bad entries, out-of-range and circular links.
// Random requests then build chains and scan them under several walk limits.
// Every result is compared field by field against a typed-in or predicted value.
// ----------------------------------------------------------------------------
module fat16_chain_analyzer_test;

  // Opcode 3 is not decoded by the block; it must come back all zero.
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  // Reserved entry values: neither free, bad, link nor end marker.
  localparam logic [15:0] V_RSV_ONE      = 16'h0001;
  localparam logic [15:0] V_RSV_MIN      = 16'hFFF0;
  // Longest silent stretch: a 65535-link walk plus a full scan, several times over.
  localparam int          WATCHDOG_LIMIT = 300000;
  // Tail after the last result: longer than an analyse pass.
  localparam int          DRAIN_CYCLES   = 600;
  localparam int          PHASES         = 8;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  fca_pkg::fca_req_t req_i;
  logic              done_o;
  fca_pkg::fca_res_t res_o;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;

  fat16_chain_analyzer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block's state, advanced once per accepted request
  // --------------------------------------------------------------------------
  logic [15:0] fat_shadow     [fca_pkg::TABLE_ENTRIES];
  bit          pointed_shadow [fca_pkg::TABLE_ENTRIES];
  int          scan_pos;      // next cluster the chain scan looks at
  int          chains_seen;   // chains reported since the last analyse
  int          walk_limit;    // mirror of the length-limit register

  fca_pkg::fca_res_t pending_q [$]; // expected results, oldest first
  fca_pkg::fca_res_t oldest;
  int                mismatches;
  int                idle_cycles;
  int                calm_left;     // requests still to go with no gap in front

  // Directed stimulus: a typed-in expectation where it is obvious
  typedef struct {
    fca_pkg::fca_req_t req;
    bit                typed;
    fca_pkg::fca_res_t want;
  } probe_t;

  probe_t probes [$];

  function automatic int bump(input int c);
    return (c < 255) ? c + 1 : 255;
  endfunction

  // A link only counts if it lands inside the table
  function automatic bit table_link(input logic [15:0] v);
    return (v >= fca_pkg::V_LINK_MIN) && (v <= fca_pkg::V_LINK_MAX) &&
           (int'(v) < fca_pkg::TABLE_ENTRIES);
  endfunction

  function automatic fca_pkg::fca_res_t predict_response(input fca_pkg::fca_req_t r);
    fca_pkg::fca_res_t res;
    int                fr;
    int                us;
    int                bd;
    int                eo;
    int                pos;
    int                node;
    int                len;
    logic [15:0]       v;
    logic [1:0]        kind;
    res = '0;
    case (r.opcode)
      fca_pkg::OP_WRITE: begin
        fat_shadow[r.entry_index] = r.entry_value;
      end
      fca_pkg::OP_ANALYZE: begin
        fr = 0;
        us = 0;
        bd = 0;
        eo = 0;
        // entries 0 and 1 are the media and volume words, not clusters
        for (int i = 2; i < fca_pkg::TABLE_ENTRIES; i++) begin
          v = fat_shadow[8'(i)];
          if (v == fca_pkg::V_FREE) fr = bump(fr);
          else if (v == fca_pkg::V_BAD) bd = bump(bd);
          else if (v >= fca_pkg::V_EOC_MIN) begin
            eo = bump(eo);
            us = bump(us);
          end else if (v >= fca_pkg::V_LINK_MIN && v <= fca_pkg::V_LINK_MAX) us = bump(us);
        end
        for (int i = 0; i < fca_pkg::TABLE_ENTRIES; i++) pointed_shadow[8'(i)] = 1'b0;
        for (int i = 2; i < fca_pkg::TABLE_ENTRIES; i++) begin
          v = fat_shadow[8'(i)];
          if (table_link(v)) pointed_shadow[v[7:0]] = 1'b1;
        end
        // nothing in use: park the cursor past the end
        scan_pos    = (us == 0) ? fca_pkg::TABLE_ENTRIES : 2;
        chains_seen = 0;
        res.free_count       = fr[7:0];
        res.used_count       = us[7:0];
        res.bad_count        = bd[7:0];
        res.end_marker_count = eo[7:0];
        res.media_byte       = fat_shadow[0][7:0];
        res.volume_state     = (fat_shadow[1] == fca_pkg::V_CLEAN) ? fca_pkg::VOL_CLEAN :
                               (fat_shadow[1] == fca_pkg::V_DIRTY) ? fca_pkg::VOL_DIRTY :
                               fca_pkg::VOL_OTHER;
      end
      fca_pkg::OP_NEXT: begin
        pos = scan_pos;
        while (pos < fca_pkg::TABLE_ENTRIES && (fat_shadow[8'(pos)] == fca_pkg::V_FREE ||
               fat_shadow[8'(pos)] == fca_pkg::V_BAD || pointed_shadow[8'(pos)]))
          pos++;
        if (pos >= fca_pkg::TABLE_ENTRIES) begin
          scan_pos = fca_pkg::TABLE_ENTRIES;
        end else begin
          node = pos;
          len  = 1;
          kind = fca_pkg::END_LIMIT;
          while (len < walk_limit) begin
            v = fat_shadow[8'(node)];
            if (v >= fca_pkg::V_EOC_MIN) begin
              kind = fca_pkg::END_EOC;
              break;
            end else if (table_link(v)) begin
              node = int'(v);
              len++;
            end else begin
              kind = fca_pkg::END_BAD;
              break;
            end
          end
          scan_pos    = pos + 1;
          chains_seen = bump(chains_seen);
          res.chain_found    = 1'b1;
          res.chain_start    = pos[7:0];
          res.chain_length   = len[15:0];
          res.chain_end_kind = kind;
          res.chain_number   = chains_seen[7:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request, weighted towards writes that grow forward chains
  function automatic fca_pkg::fca_req_t draw_request();
    fca_pkg::fca_req_t r;
    int                pick;
    int                kind;
    int                tgt;
    r.entry_index = 8'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1));
    r.entry_value = 16'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60) r.opcode = fca_pkg::OP_WRITE;
    else if (pick < 88) r.opcode = fca_pkg::OP_NEXT;
    else if (pick < 98) r.opcode = fca_pkg::OP_ANALYZE;
    else r.opcode = OP_UNUSED;
    if (r.opcode == fca_pkg::OP_WRITE) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        tgt = r.entry_index + $urandom_range(1, 4);
        r.entry_value = (tgt < fca_pkg::TABLE_ENTRIES) ? 16'(tgt) :
                        fca_pkg::V_EOC_MIN + 16'($urandom_range(0, 7));
      end else if (kind < 50) begin
        r.entry_value = 16'($urandom_range(2, fca_pkg::TABLE_ENTRIES - 1));
      end else if (kind < 65) begin
        r.entry_value = fca_pkg::V_EOC_MIN + 16'($urandom_range(0, 7));
      end else if (kind < 77) begin
        r.entry_value = fca_pkg::V_FREE;
      end else if (kind < 82) begin
        r.entry_value = fca_pkg::V_BAD;
      end else if (kind < 87) begin
        r.entry_value = ($urandom_range(0, 1) != 0) ? V_RSV_ONE :
                        V_RSV_MIN + 16'($urandom_range(0, 6));
      end else if (kind < 92) begin
        r.entry_value = 16'($urandom_range(fca_pkg::TABLE_ENTRIES, fca_pkg::V_LINK_MAX));
      end else if (kind < 96) begin
        // media and volume words
        r.entry_index = 8'($urandom_range(0, 1));
        pick = $urandom_range(0, 2);
        if (pick == 0) r.entry_value = fca_pkg::V_CLEAN;
        else if (pick == 1) r.entry_value = fca_pkg::V_DIRTY;
      end
    end
    return r;
  endfunction

  // Drives one request, waits for the handshake and queues its expectation.
  // Returns in the time step of acceptance with start still high.
  task automatic issue(input fca_pkg::fca_req_t r, input bit typed,
                       input fca_pkg::fca_res_t want);
    int                gap;
    fca_pkg::fca_res_t model_res;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    // the shadow moves with every request, typed-in rows too
    model_res = predict_response(r);
    pending_q.push_back(typed ? want : model_res);
  endtask

  // Called in the step of the last acceptance: drops start, waits for the
  // block to drain, then writes the length limit
  task automatic set_walk_limit(input logic [15:0] value);
    start <= 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    walk_limit  = int'(value);
  endtask

  // Writes every entry so no later read touches an unwritten one
  task automatic wipe_table();
    fca_pkg::fca_req_t r;
    fca_pkg::fca_res_t nothing;
    nothing = '0;
    for (int i = 0; i < fca_pkg::TABLE_ENTRIES; i++) begin
      r.opcode      = fca_pkg::OP_WRITE;
      r.entry_index = 8'(i);
      r.entry_value = (i == 0) ? fca_pkg::V_EOC_MIN :
                      (i == 1) ? fca_pkg::V_CLEAN : fca_pkg::V_FREE;
      issue(r, 1'b1, nothing);
    end
  endtask

  function automatic void add_probe(input logic [1:0] op, input logic [7:0] idx,
                                    input logic [15:0] val, input bit typed,
                                    input fca_pkg::fca_res_t want);
    probe_t p;
    p.req.opcode      = op;
    p.req.entry_index = idx;
    p.req.entry_value = val;
    p.typed           = typed;
    p.want            = want;
    probes.push_back(p);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
      end else begin
        oldest = pending_q.pop_front();
        check_field("free_count", 16'(oldest.free_count), 16'(res_o.free_count));
        check_field("used_count", 16'(oldest.used_count), 16'(res_o.used_count));
        check_field("bad_count", 16'(oldest.bad_count), 16'(res_o.bad_count));
        check_field("end_marker_count", 16'(oldest.end_marker_count),
                    16'(res_o.end_marker_count));
        check_field("media_byte", 16'(oldest.media_byte), 16'(res_o.media_byte));
        check_field("volume_state", 16'(oldest.volume_state), 16'(res_o.volume_state));
        check_field("chain_found", 16'(oldest.chain_found), 16'(res_o.chain_found));
        check_field("chain_start", 16'(oldest.chain_start), 16'(res_o.chain_start));
        check_field("chain_length", oldest.chain_length, res_o.chain_length);
        check_field("chain_end_kind", 16'(oldest.chain_end_kind),
                    16'(res_o.chain_end_kind));
        check_field("chain_number", 16'(oldest.chain_number), 16'(res_o.chain_number));
      end
    end
    // any request or result moving counts as progress
    if (!rst_ni || (start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    fca_pkg::fca_res_t nothing;
    fca_pkg::fca_res_t empty_table;
    fca_pkg::fca_req_t r;
    logic [15:0]       phase_limit [PHASES];
    int                phase_items [PHASES];

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    mismatches  = 0;
    idle_cycles = 0;
    calm_left   = 0;
    for (int i = 0; i < fca_pkg::TABLE_ENTRIES; i++) begin
      fat_shadow[8'(i)]     = fca_pkg::V_FREE;
      pointed_shadow[8'(i)] = 1'b0;
    end
    scan_pos    = 2;
    chains_seen = 0;
    walk_limit  = int'(fca_pkg::LIMIT_RST);

    nothing                  = '0;
    empty_table              = '0;
    empty_table.free_count   = 8'(fca_pkg::TABLE_ENTRIES - 2);
    empty_table.media_byte   = fca_pkg::V_EOC_MIN[7:0];
    empty_table.volume_state = fca_pkg::VOL_CLEAN;

    // Walk limits per phase: both extremes, tiny values, then back to reset
    phase_limit = '{16'd0, 16'd1, 16'd2, 16'd5, 16'hFFFF, 16'd12, 16'd200,
                    fca_pkg::LIMIT_RST};
    phase_items = '{100, 100, 100, 105, 0, 150, 150, 150};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // map clearing pass after reset
    do @(posedge clk_i); while (busy);

    // Fill the table: all free, media byte F8, volume clean
    wipe_table();

    // Next-chain before any analyse: map clear, cursor at 2, nothing to find
    add_probe(fca_pkg::OP_NEXT,    8'd0,   16'h0000, 1'b1, nothing);
    add_probe(fca_pkg::OP_ANALYZE, 8'd0,   16'h0000, 1'b1, empty_table);
    // empty table parks the cursor: scan is exhausted
    add_probe(fca_pkg::OP_NEXT,    8'd0,   16'h0000, 1'b1, nothing);
    add_probe(OP_UNUSED,           8'hFF,  16'hFFFF, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd255, fca_pkg::V_CLEAN, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd1,   fca_pkg::V_DIRTY, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd0,   16'h00AB, 1'b1, nothing);
    // 2 -> 3 -> 4 -> end marker
    add_probe(fca_pkg::OP_WRITE,   8'd2,   16'h0003, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd3,   16'h0004, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd4,   fca_pkg::V_EOC_MIN, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd5,   fca_pkg::V_BAD, 1'b1, nothing);
    // reserved values start a chain that ends as invalid
    add_probe(fca_pkg::OP_WRITE,   8'd6,   V_RSV_ONE, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd7,   V_RSV_MIN, 1'b1, nothing);
    // link past the end of the table
    add_probe(fca_pkg::OP_WRITE,   8'd8,   16'h0100, 1'b1, nothing);
    // 9 <-> 10 loop, entered from 11: walk stops at the limit
    add_probe(fca_pkg::OP_WRITE,   8'd9,   16'h000A, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd10,  16'h0009, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd11,  16'h0009, 1'b1, nothing);
    add_probe(fca_pkg::OP_WRITE,   8'd12,  fca_pkg::V_LINK_MAX, 1'b1, nothing);
    add_probe(fca_pkg::OP_ANALYZE, 8'd0,   16'h0000, 1'b0, nothing);
    // seven chain starts, then the exhausted case
    for (int i = 0; i < 8; i++) add_probe(fca_pkg::OP_NEXT, 8'd0, 16'h0000, 1'b0, nothing);

    foreach (probes[i]) issue(probes[i].req, probes[i].typed, probes[i].want);

    for (int p = 0; p < PHASES; p++) begin
      set_walk_limit(phase_limit[p]);
      if (phase_limit[p] == 16'hFFFF) begin
        // fresh table with one loop entered from cluster 2: the walk runs
        // to the full 16-bit limit
        wipe_table();
        r.opcode      = fca_pkg::OP_WRITE;
        r.entry_index = 8'd2;
        r.entry_value = 16'h0003;
        issue(r, 1'b0, nothing);
        r.entry_index = 8'd3;
        r.entry_value = 16'h0004;
        issue(r, 1'b0, nothing);
        r.entry_index = 8'd4;
        r.entry_value = 16'h0003;
        issue(r, 1'b0, nothing);
        r.opcode = fca_pkg::OP_ANALYZE;
        issue(r, 1'b0, nothing);
        r.opcode = fca_pkg::OP_NEXT;
        issue(r, 1'b0, nothing);
        issue(r, 1'b0, nothing);
      end else begin
        repeat (phase_items[p]) issue(draw_request(), 1'b0, nothing);
      end
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== fat16_chain_analyzer.f =====
sv/fca_pkg.sv
sv/fca_ram.sv
sv/fca_ctrl.sv
sv/fat16_chain_analyzer.sv
sim/fat16_chain_analyzer_test.sv
